@@ src/sha1s_pkg.sv @@
package sha1s_pkg;

  localparam int unsigned WORDS     = 16;
  localparam int unsigned WADDR_W   = 4;
  localparam int unsigned ROUNDS    = 80;
  localparam int unsigned COUNT_W   = 61;

  // initial vector; element 0 is word a
  localparam logic [4:0][31:0] IV = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD_FIRST,
    ST_PAD_FILL,
    ST_OUT
  } state_t;

  // sequencer to round datapath
  typedef struct packed {
    logic       init;   // load a..e from the chaining words
    logic       latch;  // hold first pair of schedule reads
    logic       round;  // perform one round
    logic       add;    // fold a..e into the chaining words
    logic       iv;     // back to the initial vector
    logic [6:0] t;
  } core_ctrl_t;

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20) begin
      k = K0;
    end else if (t < 7'd40) begin
      k = K1;
    end else if (t < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

@@ src/sha1s_ram.sv @@
module sha1s_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ src/sha1s_core.sv @@
module sha1s_core (
  input  logic                   clk,
  input  logic                   rst,
  input  sha1s_pkg::core_ctrl_t  ctrl,
  input  logic [31:0]            q_a,
  input  logic [31:0]            q_b,
  input  logic [2:0]             idx,
  output logic [31:0]            w,
  output logic [31:0]            h_word
);

  logic [4:0][31:0] h;
  logic [31:0] a, b, c, d, e;
  logic [31:0] sched_x;
  logic [31:0] x;
  logic [31:0] f;
  logic [31:0] a_new;

  // phase 2 sees W[t-14] on port a and W[t-16] (or W[t] in the first 16) on port b
  always_comb begin
    x = sched_x ^ q_a ^ q_b;
    if (ctrl.t < 7'd16) begin
      w = q_b;
    end else begin
      w = {x[30:0], x[31]};
    end

    if (ctrl.t < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (ctrl.t < 7'd40) begin
      f = b ^ c ^ d;
    end else if (ctrl.t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end

    a_new = {a[26:0], a[31:27]} + f + e + w + sha1s_pkg::round_k(ctrl.t);
    h_word = h[idx];
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      sched_x <= q_a ^ q_b;
    end
    if (ctrl.init) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (ctrl.round) begin
      a <= a_new;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h <= sha1s_pkg::IV;
    end else if (ctrl.iv) begin
      h <= sha1s_pkg::IV;
    end else if (ctrl.add) begin
      h[0] <= h[0] + a;
      h[1] <= h[1] + b;
      h[2] <= h[2] + c;
      h[3] <= h[3] + d;
      h[4] <= h[4] + e;
    end
  end

endmodule

@@ src/sha1_stream_hasher.sv @@
// SHA-1 over a byte stream.
// msg channel (valid/ready): one request per byte; byte_present marks a data
// byte, end_of_message closes the message (with or without a byte). A request
// with neither flag is taken and ignored.
// digest channel (valid/ready): five requests per message, words a..e with
// word_index 0..4, last_word on the fifth.
// Bytes are packed four to a word into a 16 x 32 window RAM with two read
// ports, which also holds the rolling schedule during compression.
// Bytes are taken while idle; the byte that fills a block starts a compression
// of 80 rounds (two RAM read slots, then the round) plus the chaining add,
// during which msg_ready is low, so no new byte is taken until it is done.
// End of message: a pad write, fill writes to the end of the block, one or
// two compressions, then the five digest words at one per cycle while the
// receiver accepts. The fifth word sits in an output register, so the next
// message is accepted while it waits. A stalled receiver holds the block in
// the output state. After the digest the chaining words return to the
// initial vector and the count to zero.
// Reset (rst, synchronous) restores the initial vector and a zero count;
// no clearing pass is needed.
module sha1_stream_hasher (
  input  logic               clk,
  input  logic               rst,
  input  logic               msg_valid,
  output logic               msg_ready,
  input  sha1s_pkg::msg_t    msg,
  output logic               digest_valid,
  input  logic               digest_ready,
  output sha1s_pkg::digest_t digest
);

  sha1s_pkg::state_t     state, state_next;
  sha1s_pkg::core_ctrl_t ctrl;

  logic [sha1s_pkg::COUNT_W-1:0] count;
  logic [31:0] wbuf;
  logic [6:0]  t;
  logic [1:0]  phase;
  logic [3:0]  padaddr;
  logic        len_here;
  logic        pad_active;
  logic        end_pend;
  logic [2:0]  idx;

  logic        accept;
  logic        load_out;
  logic [1:0]  lane;
  logic [63:0] len_bits;
  logic [31:0] padword;
  logic [31:0] fillword;

  logic        we;
  logic [3:0]  waddr;
  logic [31:0] wdata;
  logic [3:0]  raddr_a, raddr_b;
  logic [31:0] q_a, q_b;
  logic [31:0] w;
  logic [31:0] h_word;

  assign msg_ready = (state == sha1s_pkg::ST_IDLE) && !rst;
  assign accept    = msg_valid & msg_ready;
  assign lane      = count[1:0];
  assign len_bits  = {count, 3'b000};

  // partial word: bytes so far, the pad byte, zeros
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (2'(j) < lane) begin
        padword[31-8*j -: 8] = wbuf[31-8*j -: 8];
      end else if (2'(j) == lane) begin
        padword[31-8*j -: 8] = sha1s_pkg::PAD_BYTE;
      end else begin
        padword[31-8*j -: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    if (len_here && padaddr == 4'd14) begin
      fillword = len_bits[63:32];
    end else if (len_here && padaddr == 4'd15) begin
      fillword = len_bits[31:0];
    end else begin
      fillword = '0;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    ctrl.t     = t;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    raddr_a    = '0;
    raddr_b    = '0;
    load_out   = 1'b0;
    unique case (state)
      sha1s_pkg::ST_IDLE: begin
        if (accept) begin
          if (msg.byte_present && lane == 2'd3) begin
            we    = 1'b1;
            waddr = count[5:2];
            wdata = {wbuf[31:8], msg.data_byte};
          end
          if (msg.byte_present && count[5:0] == 6'd63) begin
            ctrl.init  = 1'b1;
            state_next = sha1s_pkg::ST_ROUND;
          end else if (msg.end_of_message) begin
            state_next = sha1s_pkg::ST_PAD_FIRST;
          end
        end
      end
      sha1s_pkg::ST_ROUND: begin
        unique case (phase)
          2'd0: begin
            raddr_a = t[3:0] - 4'd3;
            raddr_b = t[3:0] - 4'd8;
          end
          2'd1: begin
            raddr_a    = t[3:0] - 4'd14;
            raddr_b    = t[3:0];
            ctrl.latch = 1'b1;
          end
          default: begin
            ctrl.round = 1'b1;
            we         = 1'b1;
            waddr      = t[3:0];
            wdata      = w;
            if (t == 7'(sha1s_pkg::ROUNDS - 1)) begin
              state_next = sha1s_pkg::ST_ADD;
            end
          end
        endcase
      end
      sha1s_pkg::ST_ADD: begin
        ctrl.add = 1'b1;
        priority if (pad_active && len_here) begin
          state_next = sha1s_pkg::ST_OUT;
        end else if (pad_active) begin
          state_next = sha1s_pkg::ST_PAD_FILL;
        end else if (end_pend) begin
          state_next = sha1s_pkg::ST_PAD_FIRST;
        end else begin
          state_next = sha1s_pkg::ST_IDLE;
        end
      end
      sha1s_pkg::ST_PAD_FIRST: begin
        we    = 1'b1;
        waddr = count[5:2];
        wdata = padword;
        if (count[5:2] == 4'd15) begin
          ctrl.init  = 1'b1;
          state_next = sha1s_pkg::ST_ROUND;
        end else begin
          state_next = sha1s_pkg::ST_PAD_FILL;
        end
      end
      sha1s_pkg::ST_PAD_FILL: begin
        we    = 1'b1;
        waddr = padaddr;
        wdata = fillword;
        if (padaddr == 4'd15) begin
          ctrl.init  = 1'b1;
          state_next = sha1s_pkg::ST_ROUND;
        end
      end
      sha1s_pkg::ST_OUT: begin
        load_out = !digest_valid || digest_ready;
        if (load_out && idx == 3'd4) begin
          ctrl.iv    = 1'b1;
          state_next = sha1s_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sha1s_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha1s_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      t            <= '0;
      phase        <= '0;
      padaddr      <= '0;
      len_here     <= 1'b0;
      pad_active   <= 1'b0;
      end_pend     <= 1'b0;
      idx          <= '0;
      digest_valid <= 1'b0;
    end else begin
      if (accept && msg.byte_present) begin
        count                  <= count + 1'b1;
        wbuf[{~lane, 3'b000} +: 8] <= msg.data_byte;
        end_pend               <= msg.end_of_message;
      end

      if (ctrl.init) begin
        t     <= '0;
        phase <= '0;
      end else if (state == sha1s_pkg::ST_ROUND) begin
        if (phase == 2'd2) begin
          phase <= '0;
          t     <= t + 7'd1;
        end else begin
          phase <= phase + 2'd1;
        end
      end

      if (state == sha1s_pkg::ST_PAD_FIRST) begin
        end_pend   <= 1'b0;
        pad_active <= 1'b1;
        len_here   <= (count[5:0] <= 6'd55);
        padaddr    <= count[5:2] + 4'd1;
      end else if (state == sha1s_pkg::ST_PAD_FILL) begin
        padaddr <= padaddr + 4'd1;
      end else if (state == sha1s_pkg::ST_ADD && pad_active && !len_here) begin
        // length did not fit: second pad block, zeros then length
        padaddr  <= '0;
        len_here <= 1'b1;
      end

      if (load_out) begin
        digest_valid       <= 1'b1;
        digest.digest_word <= h_word;
        digest.word_index  <= idx;
        digest.last_word   <= (idx == 3'd4);
        if (idx == 3'd4) begin
          idx        <= '0;
          count      <= '0;
          pad_active <= 1'b0;
          len_here   <= 1'b0;
        end else begin
          idx <= idx + 3'd1;
        end
      end else if (digest_ready) begin
        digest_valid <= 1'b0;
      end
    end
  end

  sha1s_ram #(
    .WIDTH (32),
    .DEPTH (sha1s_pkg::WORDS)
  ) u_window (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (q_a),
    .rdata_b (q_b)
  );

  sha1s_core u_core (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .q_a    (q_a),
    .q_b    (q_b),
    .idx    (idx),
    .w      (w),
    .h_word (h_word)
  );

endmodule

@@ bench/tb_sha1_stream_hasher.sv @@
`timescale 1ns / 100ps

module tb_sha1_stream_hasher;

  localparam int unsigned CYCLE_LIMIT = 500000;

  // Expected digests for the message stream: a SHA-1 predictor plus a FIFO of words due.
  class digest_scoreboard;
    logic [31:0] chain [5];
    logic [7:0]  blk_bytes [64];
    logic [60:0] byte_total;
    sha1s_pkg::digest_t digests_due [$];
    int unsigned errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      int i;
      for (i = 0; i < 5; i++) chain[i] = sha1s_pkg::IV[i];
      byte_total = '0;
    endfunction

    function int pending();
      return digests_due.size();
    endfunction

    function void run_rounds();
      logic [31:0] sched [16];
      logic [31:0] a, b, c, d, e, f, k, x, tmp;
      int t;
      for (t = 0; t < 16; t++)
        sched[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (t = 0; t < 80; t++) begin
        if (t >= 16) begin
          // rolling 16-word window
          x = sched[(t - 3) & 15] ^ sched[(t - 8) & 15] ^ sched[(t - 14) & 15]
              ^ sched[t & 15];
          sched[t & 15] = {x[30:0], x[31]};
        end
        if (t < 20) begin
          f = (b & c) | (~b & d);
          k = sha1s_pkg::K0;
        end else if (t < 40) begin
          f = b ^ c ^ d;
          k = sha1s_pkg::K1;
        end else if (t < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = sha1s_pkg::K2;
        end else begin
          f = b ^ c ^ d;
          k = sha1s_pkg::K3;
        end
        tmp = {a[26:0], a[31:27]} + f + e + sched[t & 15] + k;
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = tmp;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    function void note_request(sha1s_pkg::msg_t m);
      int used;
      int i;
      logic [63:0] bit_len;
      sha1s_pkg::digest_t w;
      if (m.byte_present) begin
        used = byte_total[5:0];
        blk_bytes[used] = m.data_byte;
        byte_total = byte_total + 1'b1;
        if (used == 63) run_rounds();
      end
      if (!m.end_of_message) return;
      used = byte_total[5:0];
      blk_bytes[used] = sha1s_pkg::PAD_BYTE;
      used++;
      // no room for the length: spill into an extra block
      if (used > 56) begin
        for (i = used; i < 64; i++) blk_bytes[i] = 8'h00;
        run_rounds();
        used = 0;
      end
      for (i = used; i < 56; i++) blk_bytes[i] = 8'h00;
      bit_len = {byte_total, 3'b000};
      for (i = 0; i < 8; i++) blk_bytes[56 + i] = bit_len[63 - 8*i -: 8];
      run_rounds();
      for (i = 0; i < 5; i++) begin
        w.digest_word = chain[i];
        w.word_index  = 3'(i);
        w.last_word   = (i == 4);
        digests_due.push_back(w);
      end
      restart();
    endfunction

    function void check_word(sha1s_pkg::digest_t got);
      sha1s_pkg::digest_t want;
      if (digests_due.size() == 0) begin
        $display("%0t: digest word %h with nothing due", $time, got);
        errors++;
        return;
      end
      want = digests_due.pop_front();
      if (got.digest_word !== want.digest_word) begin
        $display("%0t: digest_word expected %h got %h", $time, want.digest_word,
                 got.digest_word);
        errors++;
      end
      if (got.word_index !== want.word_index) begin
        $display("%0t: word_index expected %0d got %0d", $time, want.word_index,
                 got.word_index);
        errors++;
      end
      if (got.last_word !== want.last_word) begin
        $display("%0t: last_word expected %b got %b", $time, want.last_word,
                 got.last_word);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               msg_valid;
  logic               msg_ready;
  sha1s_pkg::msg_t    msg;
  logic               digest_valid;
  logic               digest_ready;
  sha1s_pkg::digest_t digest;

  digest_scoreboard book;
  int unsigned cycles;
  int unsigned byte_items;
  int unsigned messages;

  sha1_stream_hasher dut (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_ready    (msg_ready),
    .msg          (msg),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest       (digest)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    msg_valid = 1'b0;
    msg = '0;
    digest_ready = 1'b0;
    cycles = 0;
    byte_items = 0;
    messages = 0;
    book = new();
  end

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // random gaps on both sides, with a quiet window where neither side idles
  function automatic bit idle_now();
    return (cycles < 1500 || cycles >= 4500) && ($urandom_range(99) < 23);
  endfunction

  always @(posedge clk) begin
    if (!rst && digest_valid && digest_ready) book.check_word(digest);
    digest_ready <= rst ? 1'b0 : !idle_now();
  end

  task automatic send_request(input sha1s_pkg::msg_t m);
    while (idle_now()) begin
      msg_valid <= 1'b0;
      @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg <= m;
    @(posedge clk);
    while (!msg_ready) @(posedge clk);
    book.note_request(m);
  endtask

  task automatic send_item(input logic [7:0] b, input logic present, input logic fin);
    sha1s_pkg::msg_t m;
    m.data_byte = b;
    m.byte_present = present;
    m.end_of_message = fin;
    send_request(m);
    if (present || fin) byte_items++;
  endtask

  // hold off the sender until every digest word due has been taken
  task automatic wait_drained();
    msg_valid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  task automatic send_message(input int len);
    int n;
    bit end_alone;
    end_alone = (len == 0) || $urandom_range(1);
    for (n = 0; n < len; n++) begin
      if ($urandom_range(19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (n == len - 1) && !end_alone);
    end
    if (end_alone) send_item(8'($urandom), 1'b0, 1'b1);
    messages++;
  endtask

  // lengths around the padding boundaries get half of the weight
  function automatic int pick_length();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) return $urandom_range(12);
    if (sel == 9) return $urandom_range(130);
    case ($urandom_range(8))
      0: return 55;
      1: return 56;
      2: return 57;
      3: return 63;
      4: return 64;
      5: return 65;
      6: return 119;
      7: return 120;
      default: return 128;
    endcase
  endfunction

  initial begin
    int len;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty message
    send_item(8'h00, 1'b0, 1'b1);
    // ignored request
    send_item(8'hff, 1'b0, 1'b0);
    // "abc", last byte carries the end
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // extremes, then a separate end request
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    // ignored request inside a message
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'haa, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    wait_drained();

    // keep the total near a hundred requests
    while (byte_items < 100) begin
      len = pick_length();
      if (len > 100 - int'(byte_items)) len = 100 - int'(byte_items);
      send_message(len);
      if ($urandom_range(7) == 0) wait_drained();
    end

    wait_drained();
    repeat (300) @(posedge clk);
    if (book.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

endmodule
